FILE: src/cntg_pkg.sv
`timescale 1ns / 1ps

package cntg_pkg;

    // Field and register widths fixed by the data formats.
    localparam int VAL_W     = 16;  // Q3.12 sample
    localparam int SQ_W      = 31;  // Q6.24 square, at most 2^30
    localparam int SUM_W     = 35;  // Q10.24 accumulator
    localparam int DIM_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPSULE_DIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SQ = 2'd1;

    // Register reset values.
    localparam logic [DIM_W-1:0] DIM_RESET = 5'd8;
    localparam logic [SUM_W-1:0] THR_RESET = 35'd16777216;

    typedef enum logic [1:0] {
        S_IDLE,     // taking elements of a capsule
        S_ADD,      // last square goes into the sum
        S_CMP,      // sum against threshold, first buffer read
        S_DRAIN     // one result per cycle
    } t_state;

endpackage

FILE: src/cntg_buf.sv
`timescale 1ns / 1ps

// Element buffer: one write port, one read port, registered read data.
module cntg_buf
    import cntg_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/capsule_norm_threshold_gate.sv
`timescale 1ns / 1ps
// A capsule's first result appears once the beat of its last element has passed the add and compare states.
// Throughput: one element per cycle while a capsule fills; a capsule then holds the block busy
// while it is gated and read back, one result per cycle through the single read port of the
// element buffer. The receiver cannot stall, so results never wait.
// Reset (i_rst_n low, synchronous) restores capsule_dim 8 and threshold_sq 2^24, empties the sum
// and count and returns to idle; buffer contents are not cleared.

module capsule_norm_threshold_gate
    import cntg_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Element beats.
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  logic signed [15:0]   i_activation,
    input  logic signed [15:0]   i_gradient,

    // Result beats, one cycle each.
    output logic                 o_valid,
    output logic signed [15:0]   o_out_value,
    output logic                 o_gated,
    output logic                 o_last_of_capsule,

    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SUM_W-1:0]     i_cfg_data
);

    // CW holds a count up to MAX_DIM; AW addresses the buffer; EW is wide enough to compare
    // a count with both the register value and MAX_DIM.
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EW = (CW > DIM_W) ? CW : DIM_W;

    t_state r_state, n_state;

    logic [DIM_W-1:0] r_dim;
    logic [SUM_W-1:0] r_thr;
    logic [CW-1:0]    r_count;
    logic             r_mode;
    logic [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]  r_sq;
    logic             r_sq_vld;
    logic [AW-1:0]    r_last_idx;
    logic [AW-1:0]    r_out_idx;
    logic             r_gate;

    logic                 w_accept;
    logic [EW-1:0]        w_eff_dim;
    logic [EW-1:0]        w_cnt_next;
    logic                 w_complete;
    logic                 w_mode;
    logic [VAL_W-1:0]     w_pass;
    logic signed [31:0]   w_prod;
    logic [SUM_W:0]       w_sum_wide;
    logic [SUM_W-1:0]     w_sum_sat;
    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    logic [VAL_W-1:0]     w_rd_data;
    logic                 w_drain_last;

    // The configuration port never pushes back.
    assign o_cfg_ready = 1'b1;

    assign w_accept = start && !busy;

    // The dimension is clamped into 1..MAX_DIM on every element.
    always_comb begin
        w_eff_dim = EW'(r_dim);
        if (w_eff_dim == '0) begin
            w_eff_dim = EW'(1);
        end else if (w_eff_dim > EW'(MAX_DIM)) begin
            w_eff_dim = EW'(MAX_DIM);
        end
    end

    // A capsule completes once the count reaches the current effective dimension.
    assign w_cnt_next = EW'(r_count) + EW'(1);
    assign w_complete = (w_cnt_next >= w_eff_dim);

    // Mode is taken from the first element of each capsule and held for the rest.
    assign w_mode = (r_count == '0) ? i_mode : r_mode;
    assign w_pass = w_mode ? i_gradient : i_activation;

    // The square is registered; the saturating add happens on the following cycle.
    assign w_prod     = i_activation * i_activation;
    assign w_sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
    assign w_sum_sat  = w_sum_wide[SUM_W] ? '1 : w_sum_wide[SUM_W-1:0];

    assign w_drain_last = (r_out_idx == r_last_idx);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_complete) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (w_drain_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs and buffer read requests. The compare cycle fetches entry zero; each drain
    // cycle shows one entry and, unless it is the last, fetches the next.
    always_comb begin
        busy      = 1'b1;
        o_valid   = 1'b0;
        w_rd_en   = 1'b0;
        w_rd_addr = r_out_idx + AW'(1);
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_ADD: begin
            end
            S_CMP: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
            end
            S_DRAIN: begin
                o_valid = 1'b1;
                w_rd_en = !w_drain_last;
            end
            default: begin
            end
        endcase
    end

    assign o_out_value       = (o_valid && !r_gate) ? w_rd_data : '0;
    assign o_gated           = o_valid && r_gate;
    assign o_last_of_capsule = o_valid && w_drain_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dim      <= DIM_RESET;
            r_thr      <= THR_RESET;
            r_count    <= '0;
            r_mode     <= 1'b0;
            r_sum      <= '0;
            r_sq_vld   <= 1'b0;
            r_last_idx <= '0;
            r_out_idx  <= '0;
            r_gate     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sq_vld <= w_accept;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_CAPSULE_DIM) begin
                    r_dim <= i_cfg_data[DIM_W-1:0];
                end else if (i_cfg_index == CFG_THRESHOLD_SQ) begin
                    r_thr <= i_cfg_data;
                end
            end

            if (w_accept) begin
                r_mode <= w_mode;
                if (w_complete) begin
                    r_count    <= '0;
                    r_last_idx <= r_count[AW-1:0];
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end

            // The sum is cleared when the gate decision is taken.
            if (r_state == S_CMP) begin
                r_gate    <= (r_sum > r_thr);
                r_sum     <= '0;
                r_out_idx <= '0;
            end else begin
                if (r_sq_vld) begin
                    r_sum <= w_sum_sat;
                end
                if (r_state == S_DRAIN) begin
                    r_out_idx <= r_out_idx + AW'(1);
                end
            end
        end
    end

    // Square of the element, Q6.24; a square of a 16-bit value fits in 31 bits.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sq <= w_prod[SQ_W-1:0];
        end
    end

    cntg_buf #(
        .DEPTH (MAX_DIM),
        .AW    (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_pass),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

endmodule

FILE: src/cntg_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the result stream of the gate.
module cntg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic [15:0] o_out_value,
    input logic        o_gated,
    input logic        o_last_of_capsule
);

    // Results are only shown while new elements are refused.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat while block accepts elements");

    // A capsule drains in consecutive cycles until its last element.
    a_drain_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_capsule) |=> o_valid)
        else $error("gap inside a capsule's results");

    // The last element ends the drain.
    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_capsule) |=> !o_valid)
        else $error("result beat after last of capsule");

    // A gated capsule passes only zeros.
    a_gated_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gated) |-> (o_out_value == 16'd0))
        else $error("gated result is not zero");

    // One gate decision covers the whole capsule.
    a_gate_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_capsule) |=> $stable(o_gated))
        else $error("gate changed inside a capsule");

endmodule

bind capsule_norm_threshold_gate cntg_checker u_cntg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_out_value       (o_out_value),
    .o_gated           (o_gated),
    .o_last_of_capsule (o_last_of_capsule)
);

FILE: dv/capsule_norm_threshold_gate_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the capsule norm threshold gate.
//
// Capsule elements go in as beats on the start/busy handshake. Alongside the
// DUT, the bench keeps its own model of the block: the running sum of squared
// activations, the stored value for each element and the capsule mode. Each
// time a capsule completes, the model queues one expected result beat per
// element. A separate checker process compares every result strobe with the
// oldest queued beat, field by field.
//
// Order of the run: reset defaults, field extremes with the unused register
// indexes, dimension zero, a dimension change inside a capsule, and then
// three random traffic phases. Each random phase uses several dimension and
// threshold settings.

module capsule_norm_threshold_gate_test;
    import cntg_pkg::*;

    localparam int DIM_MAX       = 16;
    localparam int SETTLE_CYCLES = 6;       // idle margin after the last expected result
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [SUM_W-1:0]       SUM_CEILING = {SUM_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0]   CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0]   CFG_SPARE_3 = 2'd3;
    localparam bit                     MODE_FWD    = 1'b0;
    localparam bit                     MODE_BWD    = 1'b1;
    localparam logic signed [VAL_W-1:0] Q_ONE      = 16'sh1000;
    localparam logic signed [VAL_W-1:0] Q_MIN      = 16'sh8000;
    localparam logic signed [VAL_W-1:0] Q_MAX      = 16'sh7FFF;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    gated;
        logic                    last;
    } t_gate_beat;

    // Clock, reset and DUT inputs. Every input is at a known value from time zero.
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    i_mode = 1'b0;
    logic signed [VAL_W-1:0] i_activation = '0;
    logic signed [VAL_W-1:0] i_gradient = '0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [SUM_W-1:0]        i_cfg_data = '0;

    logic                    busy;
    logic                    o_valid;
    logic signed [VAL_W-1:0] o_out_value;
    logic                    o_gated;
    logic                    o_last_of_capsule;
    logic                    o_cfg_ready;

    always #5 i_clk = ~i_clk;

    capsule_norm_threshold_gate #(
        .MAX_DIM(DIM_MAX)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_activation      (i_activation),
        .i_gradient        (i_gradient),
        .o_valid           (o_valid),
        .o_out_value       (o_out_value),
        .o_gated           (o_gated),
        .o_last_of_capsule (o_last_of_capsule),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Bench copy of the block: registers, element store and accumulator.
    logic [DIM_W-1:0] model_dim;
    logic [SUM_W-1:0] model_thr;
    logic [VAL_W-1:0] model_store [DIM_MAX];
    logic [SUM_W-1:0] model_sum;
    int               model_count;
    bit               model_mode;
    t_gate_beat       pending_beats [$];

    int mismatches;
    int elements_sent;
    int beats_checked;
    int gated_beats;
    int cycle_count;

    function automatic void reset_model();
        model_dim   = DIM_RESET;
        model_thr   = THR_RESET;
        model_sum   = '0;
        model_count = 0;
        model_mode  = MODE_FWD;
    endfunction

    // A programmed dimension of zero acts as one, and anything above the
    // store depth acts as the depth. The clamp is applied on every beat.
    function automatic int clamped_dim(logic [DIM_W-1:0] dim);
        if (dim == 0)
            return 1;
        if (dim > DIM_MAX)
            return DIM_MAX;
        return int'(dim);
    endfunction

    // Takes one accepted element into the model. When the count reaches the
    // current effective dimension, the capsule's result beats are queued.
    function automatic void gate_element(bit mode, logic signed [VAL_W-1:0] act,
                                         logic signed [VAL_W-1:0] grad);
        longint          a;
        longint unsigned sq;
        longint unsigned sum64;
        bit              over;
        t_gate_beat      beat;
        a     = act;
        sq    = longint'(a * a);
        sum64 = model_sum;
        // Mode is latched on the first element only. Later mode bits are ignored.
        if (model_count == 0)
            model_mode = mode;
        if (model_count < DIM_MAX)
            model_store[model_count] = model_mode ? grad : act;
        // The sum cannot saturate at this depth, but the model keeps the ceiling anyway.
        if (sum64 > longint'(SUM_CEILING) - sq)
            model_sum = SUM_CEILING;
        else
            model_sum = SUM_W'(sum64 + sq);
        model_count++;
        if (model_count < clamped_dim(model_dim))
            return;
        over = model_sum > model_thr;
        for (int k = 0; k < model_count && k < DIM_MAX; k++) begin
            beat.value = over ? '0 : model_store[k];
            beat.gated = over;
            beat.last  = (k + 1 == model_count);
            pending_beats.push_back(beat);
        end
        model_sum   = '0;
        model_count = 0;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Result checker. The receiver cannot stall, so every strobe is one beat.
    always @(posedge i_clk) begin : result_check
        t_gate_beat want;
        if (i_rst_n && o_valid) begin
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat value %0d",
                                          o_out_value));
            end else begin
                want = pending_beats.pop_front();
                beats_checked++;
                if (o_gated === 1'b1)
                    gated_beats++;
                if (o_out_value !== want.value)
                    report_mismatch($sformatf("out_value %0d, expected %0d",
                                              o_out_value, want.value));
                if (o_gated !== want.gated)
                    report_mismatch($sformatf("gated %b, expected %b", o_gated, want.gated));
                if (o_last_of_capsule !== want.last)
                    report_mismatch($sformatf("last_of_capsule %b, expected %b",
                                              o_last_of_capsule, want.last));
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, pending_beats.size());
            $display("status: fail");
            $finish;
        end
    end

    // Sends one element beat. It is called at a clock edge and returns at the
    // edge where the beat was taken, with start still high. The next beat can
    // then follow back to back without start dropping in between.
    task automatic send_element(bit mode, logic signed [VAL_W-1:0] act,
                                logic signed [VAL_W-1:0] grad);
        start        <= 1'b1;
        i_mode       <= mode;
        i_activation <= act;
        i_gradient   <= grad;
        do @(posedge i_clk); while (busy);
        gate_element(mode, act, grad);
        elements_sent++;
    endtask

    // Idles the sender for a random number of cycles, pct percent per cycle.
    // While idle, the data lines carry junk that must not be sampled.
    task automatic sender_pause(int pct);
        while ($urandom_range(99) < pct) begin
            start        <= 1'b0;
            i_activation <= VAL_W'($urandom);
            i_gradient   <= VAL_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Waits until every expected beat has arrived, then lets the block get back
    // to idle.
    task automatic drain_and_settle();
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write. Valid is left high. The caller lowers it after its
    // last write.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SUM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CAPSULE_DIM:  model_dim = data[DIM_W-1:0];
            CFG_THRESHOLD_SQ: model_thr = data;
            default: ;
        endcase
    endtask

    // Writes both registers once the block is idle. The unused upper bits of
    // the dimension write carry noise, since only the low bits count.
    task automatic configure(logic [DIM_W-1:0] dim, logic [SUM_W-1:0] thr);
        logic [SUM_W-1:0] dim_word;
        dim_word = SUM_W'({$urandom, $urandom});
        dim_word[DIM_W-1:0] = dim;
        drain_and_settle();
        write_register(CFG_CAPSULE_DIM, dim_word);
        write_register(CFG_THRESHOLD_SQ, thr);
        i_cfg_valid <= 1'b0;
    endtask

    // A mix of full-range, small and extreme Q3.12 samples. The small ones
    // keep short capsules under typical thresholds.
    function automatic logic signed [VAL_W-1:0] random_sample();
        case ($urandom_range(3))
            0:       return $signed(VAL_W'($urandom_range(0, 8191) - 4096));
            1:       return $urandom_range(1) ? Q_MIN : Q_MAX;
            default: return $signed(VAL_W'($urandom));
        endcase
    endfunction

    // After reset: dimension 8 and a threshold of exactly 1.0. A single 1.0
    // activation makes the sum equal to the threshold, so the capsule passes.
    // Backward mode, so the gradients come out.
    task automatic test_reset_values();
        logic signed [VAL_W-1:0] grads [8];
        grads = '{Q_MAX, Q_MIN, 16'sh0000, -16'sh0001,
                  16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00};
        for (int i = 0; i < 8; i++)
            send_element(MODE_BWD, (i == 0) ? Q_ONE : '0, grads[i]);
    endtask

    // Single-element capsules at the threshold extremes. The writes to the
    // unused indexes follow the real ones in one burst. Had either of them
    // landed in a real register, the capsules that follow would not complete
    // or gate as they should.
    task automatic test_field_extremes();
        drain_and_settle();
        write_register(CFG_CAPSULE_DIM, SUM_W'(1));
        write_register(CFG_THRESHOLD_SQ, '0);
        write_register(CFG_SPARE_2, SUM_W'(4));
        write_register(CFG_SPARE_3, SUM_CEILING);
        i_cfg_valid <= 1'b0;
        send_element(MODE_FWD, '0, Q_MAX);      // a zero sum equals a zero threshold: passes
        send_element(MODE_BWD, Q_MIN, Q_MAX);   // the largest square against zero: gated
        configure(5'd1, SUM_CEILING);
        send_element(MODE_BWD, Q_MAX, Q_MIN);
    endtask

    // Dimension zero behaves as one, so every element is its own capsule.
    task automatic test_dim_zero();
        configure(5'd0, THR_RESET);
        send_element(MODE_FWD, 16'sh1001, Q_MIN);
    endtask

    // The dimension is set far above the store depth. After twelve elements
    // it is lowered to two. The next element finishes the capsule, and all
    // thirteen stored values come out.
    task automatic test_dim_change_mid_capsule();
        configure(5'd31, SUM_CEILING);
        for (int i = 0; i < 12; i++)
            send_element(MODE_FWD, i[0] ? Q_MAX : Q_MIN, 16'sh1234);
        drain_and_settle();
        write_register(CFG_CAPSULE_DIM, SUM_W'(2));
        i_cfg_valid <= 1'b0;
        send_element(MODE_BWD, Q_MIN, -16'sh0002);
    endtask

    // Random elements under several settings. Most dimensions are small, but
    // some are zero, exactly the depth, or past the depth. Thresholds scale
    // with the dimension, so gated and passed capsules both occur.
    task automatic test_random_traffic(int idle_pct, int n_items);
        logic [DIM_W-1:0] dim;
        logic [SUM_W-1:0] thr;
        int               eff;
        for (int s = 0; s < 3; s++) begin
            case ($urandom_range(9))
                0:       dim = '0;
                1:       dim = DIM_W'($urandom_range(DIM_MAX + 1, 31));
                2:       dim = DIM_W'(DIM_MAX);
                default: dim = DIM_W'($urandom_range(1, 6));
            endcase
            eff = clamped_dim(dim);
            case ($urandom_range(7))
                0:       thr = '0;
                1:       thr = SUM_CEILING;
                default: thr = SUM_W'(longint'(eff) * longint'($urandom_range(0, 1 << 29)));
            endcase
            configure(dim, thr);
            for (int i = 0; i < n_items / 3; i++) begin
                send_element(bit'($urandom_range(1)), random_sample(), random_sample());
                sender_pause(idle_pct);
            end
        end
    endtask

    initial begin
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_field_extremes();
        test_dim_zero();
        test_dim_change_mid_capsule();
        test_random_traffic(0, 45);     // back-to-back beats
        test_random_traffic(73, 45);    // sparse sender
        test_random_traffic(21, 45);    // light gaps

        drain_and_settle();
        $display("covered %0d elements and %0d result beats, %0d of them gated,",
                 elements_sent, beats_checked, gated_beats);
        $display("over reset values, extremes, clamped and changed dimensions: %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
